### hdl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants shared by the publish packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 15;
  localparam int unsigned TopicW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned FifoPtrW = 2;
  localparam int unsigned FifoCntW = FifoPtrW + 1;
  localparam int unsigned FifoDepth = 1 << FifoPtrW;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_TLHI,
    PH_TLLO,
    PH_TOPIC,
    PH_VALUE,
    PH_DRAIN,
    PH_BAD
  } phase_e;

  typedef enum logic [1:0] {
    CL_PUB,
    CL_PING,
    CL_UNK
  } class_e;

  typedef enum logic [1:0] {
    KIND_TOPIC,
    KIND_VALUE,
    KIND_STATUS,
    KIND_RAW
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_PING,
    ST_UNKNOWN,
    ST_INVALID
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PUBLISH_CODE,
    CFG_PING_REQ_CODE,
    CFG_PING_RESP_CODE,
    CFG_BUFFER_LENGTH,
    CFG_TOPIC_LIMIT,
    CFG_VALUE_LIMIT
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] publish_code;
    logic [ByteW-1:0] ping_request_code;
    logic [ByteW-1:0] ping_response_code;
    logic [LenW-1:0]  buffer_length;
    logic [LenW-1:0]  topic_limit;
    logic [LenW-1:0]  value_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    publish_code:       8'd48,
    ping_request_code:  8'd192,
    ping_response_code: 8'd208,
    buffer_length:      15'd1400,
    topic_limit:        15'd1400,
    value_limit:        15'd1400
  };

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

### hdl/ppp_if.sv
// ----------------------------------------------------------------------------
// ppp_if
// Valid/ready channels for packet bytes in and parser results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppp_in_if;
  import ppp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface ppp_out_if;
  import ppp_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       item_kind;
  logic [ByteW-1:0] out_byte;
  logic [1:0]       packet_status;

  modport source (output valid, output item_kind, output out_byte, output packet_status,
                  input ready);
  modport sink   (input valid, input item_kind, input out_byte, input packet_status,
                  output ready);
endinterface

`default_nettype wire

### hdl/ppp_core.sv
// ----------------------------------------------------------------------------
// ppp_core
// Per-byte parse state and step logic; yields up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_core #(
  parameter int unsigned MAX_SIZE = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [ppp_pkg::ByteW-1:0]     byte_i,
  input  logic                          last_i,
  input  ppp_pkg::cfg_t                 cfg_i,
  output logic [1:0]                    res_cnt_o,
  output ppp_pkg::result_t [1:0]        res_o
);
  import ppp_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SIZE + 2);
  localparam int unsigned VW = ((SW > TopicW) ? SW : TopicW) + 1;
  localparam int unsigned AW = SW + 7;
  localparam logic [AW-1:0] MaxA   = AW'(MAX_SIZE);
  localparam logic [SW-1:0] SatAcc = SW'(MAX_SIZE + 1);
  localparam logic [VW-1:0] MaxV   = VW'(MAX_SIZE);

  phase_e              phase_q, phase_d;
  class_e              class_q, class_d;
  logic [SW-1:0]       acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic [LenW-1:0]     hc_q, hc_d;
  logic [SW-1:0]       total_q, total_d;
  logic [LenW-1:0]     pos_q, pos_d;
  logic [TopicW-1:0]   tl_q, tl_d;
  logic [SW-1:0]       vlen_q, vlen_d;
  logic [SW-1:0]       fe_q, fe_d;
  logic                stop_q, stop_d;

  logic [ByteW-1:0]    b_eff;
  logic                first_pub, first_ping;
  class_e              cls;
  logic [AW-1:0]       acc_or, acc_sh;
  logic                acc_big;
  logic [SW-1:0]       acc_new;
  logic                ovf_new;
  logic [LenW:0]       hc_inc, hc_inc2;
  logic [LenW-1:0]     hc_step, hc_term;
  logic [VW-1:0]       size_v;
  logic                size_bad;
  logic [TopicW-1:0]   tl_new;
  logic [VW-1:0]       tl_need;
  logic                tl_bad;
  logic [SW-1:0]       vlen_new;
  logic                in_topic;
  logic [LenW-1:0]     lim;
  logic [VW-1:0]       fe_inc, fld_len;
  logic                emit, fld_done;
  logic                fin_bad;
  logic                data_vld;
  result_t             data_res, st_res;

  // shared datapath
  always_comb begin
    b_eff      = (pos_q < cfg_i.buffer_length) ? byte_i : '0;
    first_pub  = (byte_i == cfg_i.publish_code);
    first_ping = (byte_i == cfg_i.ping_request_code) || (byte_i == cfg_i.ping_response_code);
    if (phase_q == PH_IDLE) begin
      cls = first_pub ? CL_PUB : (first_ping ? CL_PING : CL_UNK);
    end else begin
      cls = class_q;
    end

    // size field group
    acc_or  = AW'(acc_q) | AW'(b_eff[6:0]);
    acc_sh  = b_eff[7] ? {acc_or[AW-8:0], 7'b0} : acc_or;
    acc_big = (acc_sh > MaxA);
    acc_new = acc_big ? SatAcc : acc_sh[SW-1:0];
    ovf_new = ovf_q | acc_big;
    hc_inc  = {1'b0, hc_q} + (LenW+1)'(1);
    hc_step = hc_inc[LenW] ? hc_q : hc_inc[LenW-1:0];
    hc_inc2 = {1'b0, hc_step} + (LenW+1)'(b_eff[7]);
    hc_term = hc_inc2[LenW] ? '1 : hc_inc2[LenW-1:0];
    size_v  = VW'(acc_new) + VW'(hc_term);
    size_bad = ovf_new || (size_v > MaxV) ||
               ((size_v + VW'(1)) > VW'(cfg_i.buffer_length));

    // topic length
    tl_new   = (phase_q == PH_TLHI) ? {b_eff, 8'h00} : {tl_q[TopicW-1:ByteW], b_eff};
    tl_need  = VW'(hc_q) + VW'(2) + VW'(tl_new);
    tl_bad   = (VW'(tl_new) > MaxV) || (tl_need > VW'(total_q));
    vlen_new = SW'(VW'(total_q) - tl_need);

    // topic or value byte
    in_topic = (phase_q == PH_TOPIC);
    lim      = in_topic ? cfg_i.topic_limit : cfg_i.value_limit;
    fld_len  = in_topic ? VW'(tl_q) : VW'(vlen_q);
    fe_inc   = VW'(fe_q) + VW'(1);
    emit     = !stop_q && (b_eff != '0) && (fe_inc < VW'(lim));
    fld_done = (fe_inc >= fld_len);

    // header completed with zeros at an early end
    case (phase_q)
      PH_IDLE:          fin_bad = 1'b1;
      PH_SIZE:          fin_bad = size_bad || (acc_new < SW'(2));
      PH_TLHI, PH_TLLO: fin_bad = tl_bad;
      PH_BAD:           fin_bad = 1'b1;
      default:          fin_bad = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    class_d = class_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    hc_d    = hc_q;
    total_d = total_q;
    pos_d   = pos_q;
    tl_d    = tl_q;
    vlen_d  = vlen_q;
    fe_d    = fe_q;
    stop_d  = stop_q;
    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        acc_d   = '0;
        ovf_d   = 1'b0;
        hc_d    = LenW'(1);
        total_d = '0;
        tl_d    = '0;
        fe_d    = '0;
        stop_d  = 1'b0;
        pos_d   = LenW'(1);
        class_d = cls;
        if (cls == CL_PUB) begin
          phase_d = (cfg_i.buffer_length <= LenW'(4)) ? PH_BAD : PH_SIZE;
        end else begin
          phase_d = PH_DRAIN;
        end
      end else begin
        if (class_q == CL_PUB) begin
          unique case (phase_q)
            PH_SIZE: begin
              acc_d = acc_new;
              ovf_d = ovf_new;
              hc_d  = hc_step;
              if (!b_eff[7]) begin
                total_d = size_v[SW-1:0];
                phase_d = size_bad ? PH_BAD : PH_TLHI;
              end
            end
            PH_TLHI: begin
              tl_d    = tl_new;
              phase_d = PH_TLLO;
            end
            PH_TLLO: begin
              tl_d   = tl_new;
              vlen_d = vlen_new;
              fe_d   = '0;
              stop_d = 1'b0;
              if (tl_bad) begin
                phase_d = PH_BAD;
              end else if (tl_new == '0) begin
                phase_d = (vlen_new == '0) ? PH_DRAIN : PH_VALUE;
              end else begin
                phase_d = PH_TOPIC;
              end
            end
            PH_TOPIC: begin
              fe_d   = fe_inc[SW-1:0];
              stop_d = !emit;
              if (fld_done) begin
                fe_d    = '0;
                stop_d  = 1'b0;
                phase_d = (vlen_q == '0) ? PH_DRAIN : PH_VALUE;
              end
            end
            PH_VALUE: begin
              fe_d   = fe_inc[SW-1:0];
              stop_d = !emit;
              if (fld_done) begin
                phase_d = PH_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
        if (pos_q != '1) begin
          pos_d = pos_q + LenW'(1);
        end
      end
      if (last_i) begin
        phase_d = PH_IDLE;
        pos_d   = '0;
      end
    end
  end

  // results
  always_comb begin
    data_vld = 1'b0;
    data_res = '{kind: KIND_RAW, data: byte_i, status: ST_OK};
    if (cls == CL_UNK) begin
      data_vld = 1'b1;
    end else if (cls == CL_PUB && (phase_q == PH_TOPIC || phase_q == PH_VALUE) && emit) begin
      data_vld = 1'b1;
      data_res = '{kind: (in_topic ? KIND_TOPIC : KIND_VALUE), data: b_eff, status: ST_OK};
    end
    st_res = '{kind: KIND_STATUS, data: '0, status: ST_OK};
    unique case (cls)
      CL_PUB:  st_res.status = fin_bad ? ST_INVALID : ST_OK;
      CL_PING: st_res.status = ST_PING;
      default: st_res.status = ST_UNKNOWN;
    endcase
    res_o[0]  = data_vld ? data_res : st_res;
    res_o[1]  = st_res;
    res_cnt_o = step_i ? (2'(data_vld) + 2'(last_i)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      class_q <= CL_PUB;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      hc_q    <= '0;
      total_q <= '0;
      pos_q   <= '0;
      tl_q    <= '0;
      vlen_q  <= '0;
      fe_q    <= '0;
      stop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      hc_q    <= hc_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      tl_q    <= tl_d;
      vlen_q  <= vlen_d;
      fe_q    <= fe_d;
      stop_q  <= stop_d;
    end
  end

endmodule

`default_nettype wire

### hdl/ppp_result_fifo.sv
// ----------------------------------------------------------------------------
// ppp_result_fifo
// Four-entry result queue; takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  ppp_pkg::result_t [1:0] push_data_i,
  input  logic                   pop_i,
  output ppp_pkg::result_t       head_o,
  output logic                   valid_o,
  output logic                   room_o
);
  import ppp_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  pop;

  always_comb begin
    pop      = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    count_d  = count_q + FifoCntW'(push_cnt_i) - FifoCntW'(pop);
    head_o   = mem_q[rd_ptr_q];
    valid_o  = (count_q != '0);
    room_o   = (count_q <= FifoCntW'(FifoDepth - 2));
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### hdl/publish_packet_parser.sv
// ----------------------------------------------------------------------------
// publish_packet_parser
// Sorts packets by first byte and extracts topic and value bytes of publish
// packets, with a status item at the end of every packet.
// ----------------------------------------------------------------------------
// One packet byte is accepted per clock while the queue has room. Each byte
// passes an input register, is parsed combinationally against the running
// header state and pushes zero, one or two result items into a four-entry
// queue, and results reach the output from that queue. Input is taken while the
// input register is empty or the queue holds at most two items; the output
// drains one item per cycle while ready, so a stream of data bytes runs at one
// byte per cycle and each last byte with a data item also adds a status item.
`default_nettype none

module publish_packet_parser #(
  parameter int unsigned MAX_SIZE = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppp_in_if.sink                        in_ch,
  ppp_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [ppp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ppp_pkg::*;

  cfg_t               cfg_q;
  logic               iv_q;
  logic [ByteW-1:0]   ib_q;
  logic               il_q;
  logic               step;
  logic               room;
  logic               in_fire;
  logic [1:0]         res_cnt;
  result_t [1:0]      res;
  result_t            head;
  logic               head_vld;

  assign step        = iv_q && room;
  assign in_ch.ready = !iv_q || step;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PUBLISH_CODE:   cfg_q.publish_code       <= cfg_data_i[ByteW-1:0];
        CFG_PING_REQ_CODE:  cfg_q.ping_request_code  <= cfg_data_i[ByteW-1:0];
        CFG_PING_RESP_CODE: cfg_q.ping_response_code <= cfg_data_i[ByteW-1:0];
        CFG_BUFFER_LENGTH:  cfg_q.buffer_length      <= cfg_data_i[LenW-1:0];
        CFG_TOPIC_LIMIT:    cfg_q.topic_limit        <= cfg_data_i[LenW-1:0];
        CFG_VALUE_LIMIT:    cfg_q.value_limit        <= cfg_data_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ch.ready) begin
      iv_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ib_q <= in_ch.packet_byte;
      il_q <= in_ch.end_of_packet;
    end
  end

  ppp_core #(
    .MAX_SIZE (MAX_SIZE)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (ib_q),
    .last_i    (il_q),
    .cfg_i     (cfg_q),
    .res_cnt_o (res_cnt),
    .res_o     (res)
  );

  ppp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_data_i (res),
    .pop_i       (out_ch.ready),
    .head_o      (head),
    .valid_o     (head_vld),
    .room_o      (room)
  );

  assign out_ch.valid         = head_vld;
  assign out_ch.item_kind     = head.kind;
  assign out_ch.out_byte      = head.data;
  assign out_ch.packet_status = head.status;

endmodule

`default_nettype wire

### hdl/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks on the publish packet parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  ppp_in_if.sink     in_ch,
  ppp_out_if.source  out_ch
);
  import ppp_pkg::*;

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.item_kind) &&
      $stable(out_ch.out_byte) && $stable(out_ch.packet_status))
    else $error("stalled result item changed");

  // only status items carry a status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.item_kind != KIND_STATUS |-> out_ch.packet_status == ST_OK)
    else $error("data item with nonzero status");

  // status items carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.item_kind == KIND_STATUS |-> out_ch.out_byte == '0)
    else $error("status item with nonzero byte");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_ch.valid)
    else $error("result item right after reset");

  // an empty output side never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

endmodule

bind publish_packet_parser ppp_checker u_ppp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
